@@ hw/rtl/crc4bs_pkg.sv @@
package crc4bs_pkg;

    localparam int unsigned CRC_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IW  = 2;

    localparam logic [CFG_IW-1:0] CFG_IDX_POLY = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IDX_SEED = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_IDX_MSB  = 2'd2;

    localparam logic [CRC_W-1:0] POLY_RST = 4'h3;
    localparam logic [CRC_W-1:0] SEED_RST = 4'h0;
    localparam logic             MSB_RST  = 1'b1;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] seed;
        logic             msb_first;
    } t_cfg;

    function automatic logic [CRC_W-1:0] rev_nibble(input logic [CRC_W-1:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

    // Eight shift-and-reduce steps over one byte, either bit order.
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  start,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly,
        input logic              msb_first
    );
        logic [BYTE_W-1:0] wreg;
        logic [CRC_W-1:0]  rpoly;
        logic              fb;
        rpoly = rev_nibble(poly);
        if (msb_first) begin
            wreg = {start, {CRC_W{1'b0}}} ^ data;
            for (int k = 0; k < BYTE_W; k++) begin
                fb   = wreg[BYTE_W-1];
                wreg = {wreg[BYTE_W-2:0], 1'b0};
                if (fb) begin
                    wreg = wreg ^ {poly, {CRC_W{1'b0}}};
                end
            end
            return wreg[BYTE_W-1:CRC_W];
        end else begin
            wreg = {{CRC_W{1'b0}}, start} ^ data;
            for (int k = 0; k < BYTE_W; k++) begin
                fb   = wreg[0];
                wreg = {1'b0, wreg[BYTE_W-1:1]};
                if (fb) begin
                    wreg = wreg ^ {{CRC_W{1'b0}}, rpoly};
                end
            end
            return wreg[CRC_W-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/crc4_byte_stream_top.sv @@
// Channel  | valid       | stall       | payload
// ---------+-------------+-------------+---------------------------
// input    | i_in_valid  | o_in_stall  | i_data_byte, i_last_byte
// result   | o_out_valid | i_out_stall | o_crc_value
//
// One byte per cycle unless a last byte waits: an input register, the
// eight-step XOR network, then the running CRC and the result register. A
// CRC enters the result register as its last byte leaves the input register.
// Reset (synchronous) loads poly 3, seed 0, MSB first, and
// starts a new message. Only a last byte waits on a stalled result register;
// other bytes keep flowing.
module crc4_byte_stream_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [crc4bs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [crc4bs_pkg::CRC_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [crc4bs_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [crc4bs_pkg::CRC_W-1:0]    o_crc_value
);

    crc4bs_pkg::t_cfg                s_cfg;
    logic                            s_res_ready;
    logic                            s_res_load;
    logic [crc4bs_pkg::CRC_W-1:0]    s_res_crc;

    crc4bs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (s_cfg)
    );

    crc4bs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (s_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_res_ready (s_res_ready),
        .o_res_load  (s_res_load),
        .o_res_crc   (s_res_crc)
    );

    crc4bs_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_res_load),
        .i_crc       (s_res_crc),
        .o_ready     (s_res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

endmodule

@@ hw/rtl/crc4bs_cfg.sv @@
module crc4bs_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [crc4bs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [crc4bs_pkg::CRC_W-1:0]    i_cfg_data,
    output crc4bs_pkg::t_cfg                o_cfg
);

    crc4bs_pkg::t_cfg r_cfg;
    crc4bs_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                crc4bs_pkg::CFG_IDX_POLY: n_cfg.poly      = i_cfg_data;
                crc4bs_pkg::CFG_IDX_SEED: n_cfg.seed      = i_cfg_data;
                crc4bs_pkg::CFG_IDX_MSB:  n_cfg.msb_first = i_cfg_data[0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly      <= crc4bs_pkg::POLY_RST;
            r_cfg.seed      <= crc4bs_pkg::SEED_RST;
            r_cfg.msb_first <= crc4bs_pkg::MSB_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/crc4bs_core.sv @@
module crc4bs_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  crc4bs_pkg::t_cfg                i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [crc4bs_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                            i_last_byte,
    input  logic                            i_res_ready,
    output logic                            o_res_load,
    output logic [crc4bs_pkg::CRC_W-1:0]    o_res_crc
);

    logic                            r_valid;
    logic [crc4bs_pkg::BYTE_W-1:0]   r_data;
    logic                            r_last;
    logic [crc4bs_pkg::CRC_W-1:0]    r_crc;
    logic                            r_at_start;

    logic                            s_fire;
    logic                            s_take;
    logic [crc4bs_pkg::CRC_W-1:0]    s_start;
    logic [crc4bs_pkg::CRC_W-1:0]    n_crc;

    // A non-last byte produces no result, so it never waits on the output side.
    assign s_fire     = r_valid && (!r_last || i_res_ready);
    assign o_in_stall = r_valid && !s_fire;
    assign s_take     = i_in_valid && !o_in_stall;

    assign s_start = r_at_start ? i_cfg.seed : r_crc;
    assign n_crc   = crc4bs_pkg::crc_byte(s_start, r_data, i_cfg.poly, i_cfg.msb_first);

    assign o_res_load = s_fire && r_last;
    assign o_res_crc  = n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_crc      <= '0;
            r_at_start <= 1'b1;
        end else begin
            if (s_take) begin
                r_valid <= 1'b1;
            end else if (s_fire) begin
                r_valid <= 1'b0;
            end
            if (s_fire) begin
                r_crc      <= n_crc;
                r_at_start <= r_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && r_last |=> r_at_start)
        else $error("message start not set after last byte");

    a_mid_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && !r_last |=> !r_at_start)
        else $error("message start set inside a message");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_res_ready)
        else $error("result loaded while output register busy");

endmodule

@@ hw/rtl/crc4bs_out.sv @@
module crc4bs_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [crc4bs_pkg::CRC_W-1:0]    i_crc,
    output logic                            o_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [crc4bs_pkg::CRC_W-1:0]    o_crc_value
);

    logic                         r_valid;
    logic [crc4bs_pkg::CRC_W-1:0] r_crc;

    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_crc <= i_crc;
        end
    end

    assign o_out_valid = r_valid;
    assign o_crc_value = r_crc;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES = 150;

    class crc_scoreboard;
        logic [crc4bs_pkg::CRC_W-1:0] poly;
        logic [crc4bs_pkg::CRC_W-1:0] seed;
        logic                         msb_first;
        logic [crc4bs_pkg::CRC_W-1:0] crc_so_far;
        bit                           msg_start;
        logic [crc4bs_pkg::CRC_W-1:0] crc_due[$];
        int unsigned                  n_fail;

        function new();
            poly       = crc4bs_pkg::POLY_RST;
            seed       = crc4bs_pkg::SEED_RST;
            msb_first  = crc4bs_pkg::MSB_RST;
            crc_so_far = '0;
            msg_start  = 1'b1;
            n_fail     = 0;
        endfunction

        function void set_reg(input logic [crc4bs_pkg::CFG_IW-1:0] idx,
                              input logic [crc4bs_pkg::CRC_W-1:0] val);
            case (idx)
                crc4bs_pkg::CFG_IDX_POLY: poly = val;
                crc4bs_pkg::CFG_IDX_SEED: seed = val;
                crc4bs_pkg::CFG_IDX_MSB:  msb_first = val[0];
                default: ;
            endcase
        endfunction

        // Bit-serial form: feed one data bit per step into the 4-bit register.
        function logic [crc4bs_pkg::CRC_W-1:0] fold_byte(
            input logic [crc4bs_pkg::CRC_W-1:0]  start,
            input logic [crc4bs_pkg::BYTE_W-1:0] b
        );
            logic [crc4bs_pkg::CRC_W-1:0] r;
            logic                         fb;
            int                           k;
            r = start;
            for (k = 0; k < crc4bs_pkg::BYTE_W; k++) begin
                if (msb_first) begin
                    fb = r[crc4bs_pkg::CRC_W-1] ^ b[crc4bs_pkg::BYTE_W-1-k];
                    r  = {r[crc4bs_pkg::CRC_W-2:0], 1'b0};
                    if (fb) r = r ^ poly;
                end else begin
                    fb = r[0] ^ b[k];
                    r  = {1'b0, r[crc4bs_pkg::CRC_W-1:1]};
                    if (fb) r = r ^ {poly[0], poly[1], poly[2], poly[3]};
                end
            end
            return r;
        endfunction

        function void note_byte(input logic [crc4bs_pkg::BYTE_W-1:0] b, input logic last);
            crc_so_far = fold_byte(msg_start ? seed : crc_so_far, b);
            msg_start  = last;
            if (last) crc_due.push_back(crc_so_far);
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            n_fail++;
        endtask

        task check_crc(input logic [crc4bs_pkg::CRC_W-1:0] got);
            logic [crc4bs_pkg::CRC_W-1:0] want;
            if (crc_due.size() == 0) begin
                report($sformatf("crc_value %h with no message pending", got));
            end else begin
                want = crc_due.pop_front();
                if (got !== want) report($sformatf("crc_value got %h want %h", got, want));
            end
        endtask
    endclass

    logic                              i_clk;
    logic                              i_rst_n      = 1'b0;
    logic                              i_cfg_wr_en  = 1'b0;
    logic [crc4bs_pkg::CFG_IW-1:0]     i_cfg_index  = crc4bs_pkg::CFG_IDX_POLY;
    logic [crc4bs_pkg::CRC_W-1:0]      i_cfg_data   = '0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_stall;
    logic [crc4bs_pkg::BYTE_W-1:0]     i_data_byte  = '0;
    logic                              i_last_byte  = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall  = 1'b0;
    logic [crc4bs_pkg::CRC_W-1:0]      o_crc_value;

    crc_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          pressure_go   = 1'b0;
    bit          pressure_seen = 1'b0;
    int unsigned hold_left     = 0;

    crc4_byte_stream_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check each transaction, then pick next cycle's stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_crc(o_crc_value);
        if (pressure_go != pressure_seen) begin
            pressure_seen = pressure_go;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [crc4bs_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b, last);
    endtask

    // Drop valid and let the pipeline drain, including bytes with no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.crc_due.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [crc4bs_pkg::CFG_IW-1:0] idx,
                             input logic [crc4bs_pkg::CRC_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_cfg(input logic [crc4bs_pkg::CRC_W-1:0] poly,
                             input logic [crc4bs_pkg::CRC_W-1:0] seed,
                             input logic msb);
        write_reg(crc4bs_pkg::CFG_IDX_POLY, poly);
        write_reg(crc4bs_pkg::CFG_IDX_SEED, seed);
        write_reg(crc4bs_pkg::CFG_IDX_MSB, {{(crc4bs_pkg::CRC_W-1){1'b0}}, msb});
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random(input int n_items, input int max_len);
        int                            left;
        int                            n;
        logic [crc4bs_pkg::BYTE_W-1:0] b;
        left = 0;
        for (n = 0; n < n_items; n++) begin
            if (left == 0) begin
                left = ($urandom_range(15) == 0) ? $urandom_range(24, 1)
                                                 : $urandom_range(max_len, 1);
            end
            case ($urandom_range(9))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = crc4bs_pkg::BYTE_W'($urandom_range(255));
            endcase
            left--;
            send_byte(b, left == 0);
        end
    endtask

    function automatic logic [crc4bs_pkg::CRC_W-1:0] pick_nibble();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return crc4bs_pkg::CRC_W'($urandom_range(15));
        endcase
    endfunction

    initial begin
        int seg;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct <= 80;

        // Reset configuration: single-byte and multi-byte messages.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h12, 1'b0);
        // Change poly and bit order mid-message; the new seed waits for the next message.
        settle();
        write_cfg(4'hF, 4'hA, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h56, 1'b1);
        send_byte(8'hAA, 1'b0);
        settle();
        write_cfg(4'h0, 4'hF, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        settle();
        write_cfg(4'h0, 4'h0, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();
        write_cfg(4'hF, 4'hF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b1);

        for (seg = 0; seg < 10; seg++) begin
            settle();
            write_cfg(pick_nibble(), pick_nibble(), 1'($urandom_range(1)));
            if (seg < 3) begin
                send_idle_pct = 18;
                recv_idle_pct <= 80;
            end else if (seg < 6) begin
                send_idle_pct = 80;
                recv_idle_pct <= 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (seg == 1 || seg == 8) begin
                // Hold the result side off while short messages keep coming.
                pressure_go <= ~pressure_go;
                send_random(50, 2);
            end
            send_random(120, 8);
        end

        settle();
        if (sb.n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
